// ----- rtl/core/rbfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor package
// Widths, register map, sequencer states and the divider request and
// response types that the extractor modules share.
// ----------------------------------------------------------------------------
package rbfe_pkg;

    // Item field widths
    localparam int LEVEL_W = 8;
    localparam int RUN_W   = 8;
    localparam int SIZE_W  = 16;
    localparam int SUM_W   = 24;
    localparam int TIME_W  = 32;
    localparam int SEEN_W  = 8;
    localparam int IDX_W   = 7;
    localparam int MEAN_W  = 12;

    // The mean never exceeds 4096, so thirteen quotient bits suffice.
    localparam int QUO_W      = 13;
    localparam int DIVIDEND_W = SUM_W + 4;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 12'd4080;

    // Bursts past this count within one record are flagged.
    localparam int MAX_BURSTS = 128;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 136;
    localparam int M_TUSER_W = 2;

    // Register map
    localparam int                  PADDR_W           = 3;
    localparam int                  PDATA_W           = 32;
    localparam logic [PADDR_W-1:0]  ADDR_MAX_POWER    = 3'd0;
    localparam logic [LEVEL_W-1:0]  MAX_POWER_RESET   = 8'd16;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [SIZE_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/rbfe_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor configuration registers
// APB-style register slave holding the highest level that may open a burst.
// ----------------------------------------------------------------------------
module rbfe_cfg
    import rbfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [LEVEL_W-1:0] max_power_level
);

    logic [LEVEL_W-1:0] max_power_reg;
    logic               wr_en;

    // Zero wait states on every access.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_MAX_POWER);

    // Register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_power_reg <= MAX_POWER_RESET;
        end
        else if (wr_en)
        begin
            max_power_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // Read-back; unmapped addresses read as zero.
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_MAX_POWER)
        begin
            prdata = {{(PDATA_W-LEVEL_W){1'b0}}, max_power_reg};
        end
    end

    assign max_power_level = max_power_reg;

endmodule

// ----- rtl/core/rbfe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor divider
// Restoring divider with one shared compare and subtract unit, producing
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbfe_div
    import rbfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [QUO_W-1:0]  shq_reg;
    logic [QUO_W-1:0]  shq_next;
    logic [SIZE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              qbit;

    // Shared compare and subtract: the partial remainder always stays below
    // the divisor, so the difference fits back into the remainder width.
    assign trial = {rem_reg, shq_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    // Iteration control.
    always_comb
    begin
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // The upper dividend bits are already below the divisor because
            // the quotient fits in thirteen bits.
            rem_next  = {{(SIZE_W-(DIVIDEND_W-QUO_W)+1){1'b0}},
                         req.dividend[DIVIDEND_W-1:QUO_W+1]};
            rem_next  = {rem_next[SIZE_W-2:0], req.dividend[QUO_W]};
            shq_next  = req.dividend[QUO_W-1:0];
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            shq_next = {shq_reg[QUO_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shq_reg <= shq_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = shq_reg;

endmodule

// ----- rtl/core/rssi_burst_feature_extractor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor
// Turns run-length coded RSSI entries into busy-burst features and running
// idle and busy sample counts, one result item per input item.
// ----------------------------------------------------------------------------
// Each accepted entry yields exactly one result item. An entry that closes a
// burst (the first idle entry after busy ones, or an end-of-record mark with
// a burst pending) passes through the 13-step shift-subtract divider that
// forms the mean power before it is pushed to the output register; any
// other entry is pushed straight from the staging registers. The block
// works on one entry at a time, but accepts the next entry while the
// previous result still waits in the output register. The threshold
// register may be written only while no entry is in flight.
// ----------------------------------------------------------------------------
module rssi_burst_feature_extractor_core
    import rbfe_pkg::*;
#(
    parameter int BURST_LIMIT = MAX_BURSTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input entries
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] power_level, [15:8] run_len
    input  logic                 s_tuser,   // [0] start_of_record
    input  logic                 s_tlast,   // end_of_record
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] burst_len, [27:16] mean_power, [59:28] burst_start,
    // [66:60] burst_index, [98:67] free_count, [130:99] busy_count,
    // [135:131] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] burst_valid, [1] burst_overflow
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int PAD_W = M_TDATA_W - (SIZE_W + MEAN_W + TIME_W + IDX_W + 2 * TIME_W);

    // Configuration
    logic [LEVEL_W-1:0] max_power_level;

    rbfe_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_power_level (max_power_level)
    );

    // Sequencer and record state
    state_t              state_reg;
    state_t              state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   idle_reg;
    logic [TIME_W-1:0]   active_reg;
    logic [SEEN_W-1:0]   seen_reg;

    // Staged result of the entry in flight
    logic                res_emit_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic [TIME_W-1:0]   res_start_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic                res_ovf_reg;
    logic [TIME_W-1:0]   res_free_reg;
    logic [TIME_W-1:0]   res_busy_reg;

    // Output register
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    // Entry decode
    logic [LEVEL_W-1:0]  level;
    logic [RUN_W-1:0]    run;
    logic                sor;
    logic                eor;
    logic                acc;
    logic                out_free;
    logic                load_out;

    logic [TIME_W-1:0]   t0;
    logic [TIME_W-1:0]   i0;
    logic [TIME_W-1:0]   a0;
    logic [SEEN_W-1:0]   bs0;
    logic                is_open;
    logic                skip;
    logic                busy_path;
    logic                idle_path;
    logic [2*RUN_W-1:0]  prod;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic [SIZE_W:0]     size_add;
    logic [SIZE_W-1:0]   size_sat;
    logic [TIME_W-1:0]   run_ext;
    logic [TIME_W-1:0]   t_mid;
    logic                emit;
    logic [SIZE_W-1:0]   e_size;
    logic [SUM_W-1:0]    e_sum;
    logic [TIME_W-1:0]   idle_run;
    logic [TIME_W-1:0]   busy_run;

    logic [MEAN_W-1:0]   mean;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign level = s_tdata[LEVEL_W-1:0];
    assign run   = s_tdata[LEVEL_W+RUN_W-1:LEVEL_W];
    assign sor   = s_tuser;
    assign eor   = s_tlast;
    assign acc   = s_tvalid && s_tready;

    // State as seen after a start-of-record clear.
    assign t0  = sor ? '0 : time_reg;
    assign i0  = sor ? '0 : idle_reg;
    assign a0  = sor ? '0 : active_reg;
    assign bs0 = sor ? '0 : seen_reg;

    // Classify the entry.
    assign is_open   = (size_reg != '0);
    assign skip      = !is_open && (level > max_power_level);
    assign busy_path = !skip && (level > LEVEL_W'(1));
    assign idle_path = !skip && !busy_path;

    // Saturating burst accumulation.
    assign prod     = level * run;
    assign sum_add  = {1'b0, sum_reg} + {{(SUM_W+1-2*RUN_W){1'b0}}, prod};
    assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign size_add = {1'b0, size_reg} + {{(SIZE_W+1-RUN_W){1'b0}}, run};
    assign size_sat = size_add[SIZE_W] ? {SIZE_W{1'b1}} : size_add[SIZE_W-1:0];

    // Time at the point a burst would close; idle runs are added after it.
    assign run_ext  = {{(TIME_W-RUN_W){1'b0}}, run};
    assign t_mid    = busy_path ? (t0 + run_ext) : t0;
    assign idle_run = idle_path ? run_ext : '0;
    assign busy_run = busy_path ? run_ext : '0;

    // A burst closes on the first idle entry or is flushed at end of record.
    assign emit   = (idle_path && is_open) || (eor && busy_path && (size_sat != '0));
    assign e_size = busy_path ? size_sat : size_reg;
    assign e_sum  = busy_path ? sum_sat : sum_reg;

    // Divider for the mean power.
    assign div_req.start    = acc && emit;
    assign div_req.dividend = {e_sum, 4'b0000};
    assign div_req.divisor  = e_size;

    rbfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clamp the mean; entries without a burst report zero.
    always_comb
    begin
        mean = '0;
        if (res_emit_reg)
        begin
            if (div_rsp.quotient > {1'b0, MEAN_MAX})
            begin
                mean = MEAN_MAX;
            end
            else
            begin
                mean = div_rsp.quotient[MEAN_W-1:0];
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = emit ? ST_DIV : ST_PUSH;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_PUSH:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Sequencer and record state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            size_reg   <= '0;
            sum_reg    <= '0;
            time_reg   <= '0;
            idle_reg   <= '0;
            active_reg <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
            begin
                if (emit)
                begin
                    size_reg <= '0;
                    sum_reg  <= '0;
                    seen_reg <= (bs0 == {SEEN_W{1'b1}}) ? bs0 : (bs0 + 1'b1);
                end
                else
                begin
                    size_reg <= busy_path ? size_sat : size_reg;
                    sum_reg  <= busy_path ? sum_sat : sum_reg;
                    seen_reg <= bs0;
                end
                time_reg   <= t_mid + idle_run;
                idle_reg   <= i0 + idle_run;
                active_reg <= a0 + busy_run;
            end
        end
    end

    // Stage the result fields of the accepted entry.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            res_emit_reg  <= emit;
            res_size_reg  <= emit ? e_size : '0;
            res_start_reg <= emit ? (t_mid - {{(TIME_W-SIZE_W){1'b0}}, e_size}) : '0;
            res_idx_reg   <= emit ? bs0[IDX_W-1:0] : '0;
            res_ovf_reg   <= emit && ({1'b0, bs0} >= (SEEN_W+1)'(BURST_LIMIT));
            res_free_reg  <= i0 + idle_run;
            res_busy_reg  <= a0 + busy_run;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= {{PAD_W{1'b0}}, res_busy_reg, res_free_reg, res_idx_reg,
                           res_start_reg, mean, res_size_reg};
            m_user_reg <= {res_ovf_reg, res_emit_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/core/rbfe_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor port checker
// Watches the stream ports of the extractor and flags input handshakes and
// result items that break its rules.
// ----------------------------------------------------------------------------
module rbfe_chk
    import rbfe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // One entry at a time: the input side closes after each accepted item.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Without a burst, every burst field reads zero.
    a_no_burst_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[66:0] == '0) && !m_tuser[1])
        else $error("burst fields set on an item without a burst");

    // A reported burst has samples and a clamped mean.
    a_burst_sane: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[15:0] != '0) && (m_tdata[27:16] <= MEAN_MAX))
        else $error("reported burst has zero size or an unclamped mean");

endmodule

bind rssi_burst_feature_extractor_core rbfe_chk u_rbfe_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/rbfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor checker
// Watches the entry, result and configuration channels of the extractor,
// keeps its own model of the burst state, and compares every result item
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module rbfe_checker
    import rbfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] power_level, [15:8] run_len
    input  logic                 s_tuser,   // [0] start_of_record
    input  logic                 s_tlast,   // end_of_record
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] burst_len, [27:16] mean_power, [59:28] burst_start,
    // [66:60] burst_index, [98:67] free_count, [130:99] busy_count,
    // [135:131] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,   // [0] burst_valid, [1] burst_overflow
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int                   err_count,
    output int                   pending,
    output int                   results_seen,
    output int                   bursts_closed
);

    localparam int unsigned SIZE_SAT = 32'h0000_FFFF;
    localparam int unsigned SUM_SAT  = 32'h00FF_FFFF;

    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
        logic [MEAN_W-1:0] mean;
        logic [TIME_W-1:0] start;
        logic [IDX_W-1:0]  index;
        logic              overflow;
        logic [TIME_W-1:0] free;
        logic [TIME_W-1:0] busy;
    } feature_t;

    // Model of the burst state and the threshold register.
    int unsigned burst_len;
    int unsigned level_sum;
    int unsigned clock_time;
    int unsigned idle_cnt;
    int unsigned busy_cnt;
    int unsigned burst_count;
    int unsigned power_limit;

    feature_t feature_q[$];
    feature_t want;
    int       mismatches;
    int       n_results;
    int       n_bursts;

    // Report the closed burst into the result and clear the open burst.
    function automatic void close_burst(ref feature_t r);
        int unsigned mean;
        mean = (level_sum << 4) / burst_len;
        if (mean > MEAN_MAX)
            mean = 32'(MEAN_MAX);
        r.valid    = 1'b1;
        r.size     = burst_len[SIZE_W-1:0];
        r.mean     = mean[MEAN_W-1:0];
        r.start    = clock_time - burst_len;
        r.index    = burst_count[IDX_W-1:0];
        r.overflow = (burst_count >= MAX_BURSTS);
        if (burst_count < 255)
            burst_count++;
        burst_len = 0;
        level_sum = 0;
    endfunction

    // Work out the result of one entry and queue it.
    function automatic void extract_features(input logic [LEVEL_W-1:0] lvl,
                                             input logic [RUN_W-1:0] run,
                                             input logic sor, input logic eor);
        feature_t    r;
        logic        closed;
        int unsigned s;
        int unsigned w;
        r      = '0;
        closed = 1'b0;
        if (sor)
        begin
            clock_time  = 0;
            idle_cnt    = 0;
            busy_cnt    = 0;
            burst_count = 0;
        end
        if (burst_len == 0 && int'(lvl) > power_limit)
        begin
            // Too strong to open a burst: skipped, time stands still.
        end
        else if (lvl > 1)
        begin
            s          = burst_len + int'(run);
            w          = level_sum + int'(lvl) * int'(run);
            burst_len  = (s > SIZE_SAT) ? SIZE_SAT : s;
            level_sum  = (w > SUM_SAT) ? SUM_SAT : w;
            busy_cnt   = busy_cnt + int'(run);
            clock_time = clock_time + int'(run);
        end
        else
        begin
            if (burst_len != 0)
            begin
                close_burst(r);
                closed = 1'b1;
            end
            clock_time = clock_time + int'(run);
            idle_cnt   = idle_cnt + int'(run);
        end
        if (eor && !closed && burst_len != 0)
            close_burst(r);
        r.free = idle_cnt;
        r.busy = busy_cnt;
        feature_q.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, exp_v, exp_v, act_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_len   = 0;
            level_sum   = 0;
            clock_time  = 0;
            idle_cnt    = 0;
            busy_cnt    = 0;
            burst_count = 0;
            power_limit = 32'(MAX_POWER_RESET);
            feature_q.delete();
            mismatches  = 0;
            n_results   = 0;
            n_bursts    = 0;
        end
        else
        begin
            // Result items first: anything accepted on the input now is younger.
            if (m_tvalid === 1'b1 && m_tready)
            begin
                n_results++;
                if (feature_q.size() == 0)
                begin
                    $display("%0t ns: result item with no expectation waiting, data 0x%0h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = feature_q.pop_front();
                    if (want.valid)
                        n_bursts++;
                    compare_field("burst_valid", 32'(want.valid), 32'(m_tuser[0]));
                    compare_field("burst_len", 32'(want.size), 32'(m_tdata[15:0]));
                    compare_field("mean_power", 32'(want.mean), 32'(m_tdata[27:16]));
                    compare_field("burst_start", want.start, m_tdata[59:28]);
                    compare_field("burst_index", 32'(want.index), 32'(m_tdata[66:60]));
                    compare_field("burst_overflow", 32'(want.overflow), 32'(m_tuser[1]));
                    compare_field("free_count", want.free, m_tdata[98:67]);
                    compare_field("busy_count", want.busy, m_tdata[130:99]);
                    compare_field("padding", 32'd0, 32'(m_tdata[135:131]));
                end
            end

            // Threshold register writes.
            if (psel && penable && pwrite && pready && paddr == ADDR_MAX_POWER)
                power_limit = 32'(pwdata[LEVEL_W-1:0]);

            if (s_tvalid && s_tready)
                extract_features(s_tdata[7:0], s_tdata[15:8], s_tuser, s_tlast);
        end
        err_count     <= mismatches;
        pending       <= feature_q.size();
        results_seen  <= n_results;
        bursts_closed <= n_bursts;
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI burst feature extractor testbench
// Drives run-length RSSI entries and threshold writes into the extractor
// with random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import rbfe_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] power_level, [15:8] run_len
    logic                 s_tuser;   // [0] start_of_record
    logic                 s_tlast;   // end_of_record
    logic                 m_tvalid;
    logic                 m_tready;
    // [15:0] burst_len, [27:16] mean_power, [59:28] burst_start,
    // [66:60] burst_index, [98:67] free_count, [130:99] busy_count,
    // [135:131] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;   // [0] burst_valid, [1] burst_overflow
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int err_count;
    int pending;
    int results_seen;
    int bursts_closed;

    // When set, neither side idles.
    logic calm;
    int   entries_sent;
    int   settings_used;
    int   threshold;

    rssi_burst_feature_extractor_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rbfe_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .err_count    (err_count),
        .pending      (pending),
        .results_seen (results_seen),
        .bursts_closed(bursts_closed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result back-pressure, changed on the falling edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = calm || ($urandom_range(0, 99) >= 32);
        end
    end

    // Watchdog: ends the run after too many cycles with nothing accepted.
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready))
                stall = 0;
            else
                stall++;
        end
        $display("Watchdog expired at %0t ns with %0d results outstanding.", $time, pending);
        $display("rssi_burst_feature_extractor_core test failed");
        $finish;
    end

    // Offer one entry after a random idle spell and hold it until accepted.
    // Called and left on a falling edge.
    task automatic send_entry(input logic [7:0] lvl, input logic [7:0] run,
                              input logic sor, input logic eor);
        while (!calm && $urandom_range(0, 99) < 32)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {run, lvl};
        s_tuser  = sor;
        s_tlast  = eor;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        entries_sent++;
    endtask

    // Wait for every result, then let the block settle, then write the threshold.
    task automatic set_threshold(input int value);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_MAX_POWER;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        threshold = value;
        settings_used++;
    endtask

    // Mostly idle and in-range busy entries so that bursts keep opening and
    // closing, with some entries of any level mixed in.
    task automatic send_random_entry();
        int          pick;
        logic [7:0]  lvl;
        logic [7:0]  run;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            lvl = 8'($urandom_range(0, 1));
        else if (pick < 85)
            lvl = 8'($urandom_range(2, (threshold > 2) ? threshold : 2));
        else
            lvl = 8'($urandom_range(0, 255));
        run = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        send_entry(lvl, run, $urandom_range(0, 99) < 2, $urandom_range(0, 99) < 8);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        calm          = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        entries_sent  = 0;
        settings_used = 0;
        threshold     = int'(MAX_POWER_RESET);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed entries under the reset threshold.
        send_entry(8'd0, 8'd255, 1'b1, 1'b0);   // idle, opens the record
        send_entry(8'd255, 8'd10, 1'b0, 1'b0);  // too strong, skipped
        send_entry(8'd17, 8'd1, 1'b0, 1'b0);    // just above threshold, skipped
        send_entry(8'd16, 8'd0, 1'b0, 1'b0);    // busy with no samples opens nothing
        send_entry(8'd2, 8'd1, 1'b0, 1'b0);     // weakest busy level opens a burst
        send_entry(8'd255, 8'd255, 1'b0, 1'b0); // strong level inside a burst counts
        send_entry(8'd16, 8'd128, 1'b0, 1'b0);
        send_entry(8'd1, 8'd3, 1'b0, 1'b0);     // idle closes the burst
        send_entry(8'd0, 8'd0, 1'b0, 1'b0);
        send_entry(8'd5, 8'd7, 1'b0, 1'b1);     // opened and flushed at once
        send_entry(8'd9, 8'd20, 1'b0, 1'b0);
        send_entry(8'd3, 8'd4, 1'b1, 1'b0);     // new record while a burst is open
        send_entry(8'd0, 8'd2, 1'b1, 1'b1);     // both marks on an idle entry
        send_entry(8'd1, 8'd1, 1'b0, 1'b1);     // end of record with nothing pending
        send_entry(8'd8, 8'd8, 1'b0, 1'b0);
        send_entry(8'd12, 8'd0, 1'b0, 1'b1);    // flush on an empty busy run
        send_entry(8'd200, 8'd2, 1'b0, 1'b0);
        send_entry(8'd2, 8'd255, 1'b1, 1'b1);   // clear, open and flush together
        send_entry(8'd1, 8'd0, 1'b0, 1'b0);

        // One huge burst that saturates both the size and the weighted sum.
        set_threshold(255);
        for (int i = 0; i < 260; i++)
            send_entry(8'd255, 8'd255, 1'b0, 1'b0);
        send_entry(8'd0, 8'd1, 1'b0, 1'b0);

        // Hundreds of one-entry bursts in one record, without idling, so the
        // burst count passes capacity and saturates.
        set_threshold($urandom_range(2, 255));
        calm = 1'b1;
        for (int i = 0; i < 270; i++)
            send_entry(8'($urandom_range(2, threshold)), 8'($urandom_range(1, 255)),
                       i == 0, 1'b1);
        calm = 1'b0;

        // Random entries under a threshold of one, the highest and random thresholds.
        set_threshold(1);
        repeat (125) send_random_entry();
        set_threshold(255);
        repeat (125) send_random_entry();
        set_threshold($urandom_range(1, 255));
        repeat (125) send_random_entry();
        set_threshold($urandom_range(1, 255));
        repeat (125) send_random_entry();

        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Sent %0d entries under %0d threshold settings after reset.",
                 entries_sent, settings_used);
        $display("Checked %0d result items, %0d of them closed bursts.",
                 results_seen, bursts_closed);
        if (err_count == 0 && pending == 0)
            $display("rssi_burst_feature_extractor_core test passed");
        else
            $display("rssi_burst_feature_extractor_core test failed");
        $finish;
    end

endmodule
